### design/kpd_pkg.sv
// Shared types and constants for the keypad debounce and press classifier.
// Holds the key code table, configuration register indexes and the event struct.
// No dependencies.
`default_nettype none

package kpd_pkg;

	localparam int ROWS  = 4;
	localparam int COLS  = 4;
	localparam int KEYS  = ROWS * COLS;
	localparam int KEY_IDX_W = $clog2(KEYS);

	localparam int MATRIX_W = 16;
	localparam int TIME_W   = 32;
	localparam int CODE_W   = 8;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd15;
	localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd1000;
	localparam logic [CFG_W-1:0] HOLD_RST      = 16'd2000;

	localparam logic [CODE_W-1:0] NO_KEY = 8'h00;

	// row-major: index row*COLS+col
	localparam logic [CODE_W-1:0] KEY_TABLE [KEYS] = '{
		"1", "2", "3", "+",
		"4", "5", "6", "-",
		"7", "8", "9", "*",
		"C", "0", "=", "/"
	};

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] short_press_max_ms;
		logic [CFG_W-1:0] hold_timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic              press_event;
		logic              release_event;
		logic              short_press_event;
		logic              hold_event;
		logic [CODE_W-1:0] event_key;
		logic [CODE_W-1:0] stable_key;
	} evt_t;

endpackage

`default_nettype wire

### design/keypad_debounce_press_classifier_unit.sv
// Keypad debounce and press classifier: top level with input and result registers.
// Depends on kpd_pkg, kpd_scan and kpd_classifier.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one poll: key_matrix and now_ms.
//   Output channel (out_valid/out_ready) returns exactly one result per poll:
//   press/release/short-press/hold flags, event_key and stable_key.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   debounce_ms (0), short_press_max_ms (1), hold_timeout_ms (2); cfg_ready
//   is always high. Write config only while no poll is in flight.
// Timing:
//   A poll is captured in the input register; its result is then captured in
//   the result register. One poll per cycle sustained unless out_ready stalls
//   the output: the matrix scan sits before the input register, the whole
//   state update between input and result registers.
// Reset:
//   arst_n clears all debounce/press state and loads the register defaults
//   15, 1000, 2000. No clearing pass; the block is ready right after reset.
// Stall:
//   With out_ready low the result holds; one more poll may enter and wait in
//   the input register, after which in_ready drops.
`default_nettype none

module keypad_debounce_press_classifier_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [kpd_pkg::MATRIX_W-1:0]   key_matrix,
	input  wire logic [kpd_pkg::TIME_W-1:0]     now_ms,

	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                press_event,
	output logic                                release_event,
	output logic                                short_press_event,
	output logic                                hold_event,
	output logic      [kpd_pkg::CODE_W-1:0]     event_key,
	output logic      [kpd_pkg::CODE_W-1:0]     stable_key,

	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [kpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [kpd_pkg::CFG_W-1:0]      cfg_data
);

	kpd_pkg::cfg_t              cfg_q;
	logic                       valid_s1;
	logic [kpd_pkg::CODE_W-1:0] raw_key;
	logic [kpd_pkg::CODE_W-1:0] raw_s1;
	logic [kpd_pkg::TIME_W-1:0] now_s1;
	logic                       out_valid_q;
	logic                       advance;
	logic                       step;
	kpd_pkg::evt_t              evt;
	kpd_pkg::evt_t              result_q;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign step      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms        <= kpd_pkg::DEBOUNCE_RST;
			cfg_q.short_press_max_ms <= kpd_pkg::SHORT_MAX_RST;
			cfg_q.hold_timeout_ms    <= kpd_pkg::HOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				kpd_pkg::CFG_DEBOUNCE:  cfg_q.debounce_ms        <= cfg_data;
				kpd_pkg::CFG_SHORT_MAX: cfg_q.short_press_max_ms <= cfg_data;
				kpd_pkg::CFG_HOLD:      cfg_q.hold_timeout_ms    <= cfg_data;
				default: ;
			endcase
		end
	end

	kpd_scan u_scan (
		.key_matrix (key_matrix),
		.raw_key    (raw_key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_key;
			now_s1 <= now_ms;
		end
	end

	kpd_classifier u_classifier (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.raw_key (raw_s1),
		.now_ms  (now_s1),
		.cfg     (cfg_q),
		.evt     (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= evt;
		end
	end

	assign out_valid         = out_valid_q;
	assign press_event       = result_q.press_event;
	assign release_event     = result_q.release_event;
	assign short_press_event = result_q.short_press_event;
	assign hold_event        = result_q.hold_event;
	assign event_key         = result_q.event_key;
	assign stable_key        = result_q.stable_key;

endmodule

`default_nettype wire

### design/kpd_scan.sv
// Matrix scan: lowest pressed index wins and maps to its ASCII code.
// Depends on kpd_pkg.
`default_nettype none

module kpd_scan (
	input  wire logic [kpd_pkg::MATRIX_W-1:0] key_matrix,
	output logic      [kpd_pkg::CODE_W-1:0]   raw_key
);

	always_comb begin
		raw_key = kpd_pkg::NO_KEY;
		for (int i = kpd_pkg::KEYS - 1; i >= 0; i--) begin
			if (key_matrix[i[kpd_pkg::KEY_IDX_W-1:0]]) begin
				raw_key = kpd_pkg::KEY_TABLE[i[kpd_pkg::KEY_IDX_W-1:0]];
			end
		end
	end

endmodule

`default_nettype wire

### design/kpd_classifier.sv
// Debounce and press classification state with next-state and event logic.
// Depends on kpd_pkg.
`default_nettype none

module kpd_classifier (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [kpd_pkg::CODE_W-1:0]  raw_key,
	input  wire logic [kpd_pkg::TIME_W-1:0]  now_ms,
	input  wire kpd_pkg::cfg_t               cfg,
	output kpd_pkg::evt_t                    evt
);

	logic [kpd_pkg::CODE_W-1:0] cand_q, acc_q, prev_q;
	logic                       dact_q, pact_q;
	logic [kpd_pkg::TIME_W-1:0] dstart_q, pstart_q;

	logic [kpd_pkg::CODE_W-1:0] cand_n, acc_n;
	logic                       dact_n, pact_n;
	logic [kpd_pkg::TIME_W-1:0] dstart_n, pstart_n;
	logic [kpd_pkg::TIME_W-1:0] d_elapsed, p_elapsed, r_elapsed;

	always_comb begin
		cand_n   = cand_q;
		dact_n   = dact_q;
		dstart_n = dstart_q;
		acc_n    = acc_q;
		pact_n   = pact_q;
		pstart_n = pstart_q;
		evt      = '0;

		if (raw_key != cand_q) begin
			cand_n   = raw_key;
			dact_n   = 1'b1;
			dstart_n = now_ms;
		end
		d_elapsed = now_ms - dstart_n;
		if (dact_n && d_elapsed >= {16'd0, cfg.debounce_ms}) begin
			dact_n = 1'b0;
			acc_n  = cand_n;
		end

		r_elapsed = now_ms - pstart_q;
		if (acc_n != prev_q) begin
			if (acc_n != kpd_pkg::NO_KEY) begin
				pstart_n        = now_ms;
				pact_n          = 1'b1;
				evt.press_event = 1'b1;
				evt.event_key   = acc_n;
			end else begin
				pact_n                = 1'b0;
				evt.short_press_event = (r_elapsed <= {16'd0, cfg.short_press_max_ms});
				evt.release_event     = 1'b1;
				evt.event_key         = prev_q;
			end
		end

		p_elapsed = now_ms - pstart_n;
		if (pact_n && p_elapsed >= {16'd0, cfg.hold_timeout_ms}) begin
			pact_n         = 1'b0;
			evt.hold_event = 1'b1;
			evt.event_key  = acc_n;
		end
		evt.stable_key = acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= '0;
			dact_q   <= 1'b0;
			dstart_q <= '0;
			acc_q    <= '0;
			prev_q   <= '0;
			pact_q   <= 1'b0;
			pstart_q <= '0;
		end else if (step) begin
			cand_q   <= cand_n;
			dact_q   <= dact_n;
			dstart_q <= dstart_n;
			acc_q    <= acc_n;
			prev_q   <= acc_n;
			pact_q   <= pact_n;
			pstart_q <= pstart_n;
		end
	end

endmodule

`default_nettype wire

### design/kpd_checker.sv
// Port-level checker for the keypad classifier, bound to the top level.
// Depends on kpd_pkg and keypad_debounce_press_classifier_unit.
`default_nettype none

module kpd_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic                         press_event,
	input wire logic                         release_event,
	input wire logic                         short_press_event,
	input wire logic                         hold_event,
	input wire logic [kpd_pkg::CODE_W-1:0]   event_key,
	input wire logic [kpd_pkg::CODE_W-1:0]   stable_key
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stable_key) && $stable(event_key))
		else $error("result changed while stalled");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && release_event |->
			stable_key == kpd_pkg::NO_KEY && event_key != kpd_pkg::NO_KEY &&
			!press_event && !hold_event)
		else $error("bad release result");

	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && press_event |->
			stable_key != kpd_pkg::NO_KEY && event_key == stable_key)
		else $error("bad press result");

	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && short_press_event |-> release_event)
		else $error("short press without release");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hold_event |->
			stable_key != kpd_pkg::NO_KEY && event_key == stable_key)
		else $error("bad hold result");

endmodule

bind keypad_debounce_press_classifier_unit kpd_checker u_kpd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.press_event       (press_event),
	.release_event     (release_event),
	.short_press_event (short_press_event),
	.hold_event        (hold_event),
	.event_key         (event_key),
	.stable_key        (stable_key)
);

`default_nettype wire

### sim/kpd_press_checker.sv
// Scoreboard for the keypad debounce and press classifier: watches the poll, config and
// result channels, predicts each result from its own copy of the debounce/press state.
// Depends on kpd_pkg for the config indexes, reset values and the event struct.
module kpd_press_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [kpd_pkg::MATRIX_W-1:0]  key_matrix,
	input  logic [kpd_pkg::TIME_W-1:0]    now_ms,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          press_event,
	input  logic                          release_event,
	input  logic                          short_press_event,
	input  logic                          hold_event,
	input  logic [kpd_pkg::CODE_W-1:0]    event_key,
	input  logic [kpd_pkg::CODE_W-1:0]    stable_key,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [kpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kpd_pkg::CFG_W-1:0]     cfg_data,
	output int                            failures,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import kpd_pkg::*;

	// row-major key legend, lowest bit first
	localparam logic [127:0] KEYPAD_CHARS = "123+456-789*C0=/";

	cfg_t        timing;
	logic [7:0]  cand_key;
	logic        settling;
	logic [31:0] settle_start;
	logic [7:0]  held_key;
	logic [7:0]  last_key;
	logic        hold_armed;
	logic [31:0] hold_start;
	evt_t        due_results[$];
	int          bad;

	function automatic logic [7:0] raw_code(logic [15:0] m);
		for (int i = 0; i < 16; i++)
			if (m[i]) return KEYPAD_CHARS[127 - 8*i -: 8];
		return NO_KEY;
	endfunction

	function automatic evt_t classify_poll(logic [15:0] m, logic [31:0] t);
		evt_t        r;
		logic [7:0]  raw;
		logic [31:0] dt;
		r = '0;
		raw = raw_code(m);
		if (raw != cand_key) begin
			cand_key = raw;
			settling = 1'b1;
			settle_start = t;
		end
		dt = t - settle_start;
		if (settling && dt >= {16'h0, timing.debounce_ms}) begin
			settling = 1'b0;
			held_key = cand_key;
		end
		if (held_key != last_key) begin
			if (held_key != NO_KEY) begin
				hold_start = t;
				hold_armed = 1'b1;
				r.press_event = 1'b1;
				r.event_key = held_key;
			end else begin
				hold_armed = 1'b0;
				dt = t - hold_start;
				r.short_press_event = (dt <= {16'h0, timing.short_press_max_ms});
				r.release_event = 1'b1;
				r.event_key = last_key;
			end
			last_key = held_key;
		end
		dt = t - hold_start;
		if (hold_armed && dt >= {16'h0, timing.hold_timeout_ms}) begin
			hold_armed = 1'b0;
			r.hold_event = 1'b1;
			r.event_key = held_key;
		end
		r.stable_key = held_key;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		evt_t want;
		evt_t got;
		if (!arst_n) begin
			timing.debounce_ms = DEBOUNCE_RST;
			timing.short_press_max_ms = SHORT_MAX_RST;
			timing.hold_timeout_ms = HOLD_RST;
			cand_key = NO_KEY;
			settling = 1'b0;
			settle_start = '0;
			held_key = NO_KEY;
			last_key = NO_KEY;
			hold_armed = 1'b0;
			hold_start = '0;
			due_results.delete();
			bad = 0;
			failures <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEBOUNCE: timing.debounce_ms = cfg_data;
					CFG_SHORT_MAX: timing.short_press_max_ms = cfg_data;
					CFG_HOLD: timing.hold_timeout_ms = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {press_event, release_event, short_press_event, hold_event,
					event_key, stable_key};
				if (due_results.size() == 0) begin
					if (bad < 10)
						$display("%0t: result transfer with nothing pending: %p", $realtime, got);
					bad++;
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						if (bad < 10) begin
							$display("%0t: mismatch", $realtime);
							$display("  expected press %b release %b short %b hold %b key %h stable %h",
								want.press_event, want.release_event, want.short_press_event,
								want.hold_event, want.event_key, want.stable_key);
							$display("  actual   press %b release %b short %b hold %b key %h stable %h",
								got.press_event, got.release_event, got.short_press_event,
								got.hold_event, got.event_key, got.stable_key);
						end
						bad++;
					end
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(classify_poll(key_matrix, now_ms));
			failures <= bad;
			outstanding <= due_results.size();
		end
	end

endmodule

### sim/tb_keypad_debounce_press_classifier_unit.sv
// Top of the keypad classifier testbench: clock, reset, poll and config stimulus with
// random idling and back-pressure, and the final verdict.
// Depends on kpd_pkg, keypad_debounce_press_classifier_unit and kpd_press_checker.
module tb_keypad_debounce_press_classifier_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import kpd_pkg::*;

	localparam int LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [MATRIX_W-1:0]  key_matrix = '0;
	logic [TIME_W-1:0]    now_ms = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 press_event;
	logic                 release_event;
	logic                 short_press_event;
	logic                 hold_event;
	logic [CODE_W-1:0]    event_key;
	logic [CODE_W-1:0]    stable_key;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
	logic [CFG_W-1:0]     cfg_data = '0;

	int          failures;
	int          pending;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_asks = 0;
	int          hold_done = 0;
	int          hold_left = 0;
	int          cycle_count = 0;
	int unsigned polls_sent = 0;
	logic [31:0] clock_ms = '0;

	keypad_debounce_press_classifier_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .key_matrix(key_matrix), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready), .press_event(press_event),
		.release_event(release_event), .short_press_event(short_press_event),
		.hold_event(hold_event), .event_key(event_key), .stable_key(stable_key),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	kpd_press_checker scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .key_matrix(key_matrix), .now_ms(now_ms),
		.out_valid(out_valid), .out_ready(out_ready), .press_event(press_event),
		.release_event(release_event), .short_press_event(short_press_event),
		.hold_event(hold_event), .event_key(event_key), .stable_key(stable_key),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .failures(failures), .outstanding(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("keypad_debounce_press_classifier_unit test failed");
			$finish;
		end
	end

	// result side: random stalls plus occasional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_asks) begin
			out_ready <= 1'b0;
			hold_left <= 300;
			hold_done <= hold_asks;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_poll(input logic [15:0] m, input logic [31:0] t);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_matrix <= m;
		now_ms <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		polls_sent++;
	endtask

	task automatic poll(input logic [15:0] m, input logic [31:0] dt);
		clock_ms = clock_ms + dt;
		send_poll(m, clock_ms);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timing(input logic [15:0] d, input logic [15:0] s, input logic [15:0] h);
		logic [15:0] vals [3];
		logic [1:0]  idx [3];
		vals = '{d, s, h};
		idx = '{CFG_DEBOUNCE, CFG_SHORT_MAX, CFG_HOLD};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// bouncy press, steady hold, maybe a roll to another key, bouncy release, idle
	task automatic key_stroke(input int unsigned step_max);
		logic [15:0] k;
		int unsigned bounce_max;
		bounce_max = step_max / 8 + 1;
		k = ($urandom_range(9) < 7) ? (16'h1 << $urandom_range(15)) : 16'($urandom);
		repeat ($urandom_range(3)) poll(16'($urandom), $urandom_range(bounce_max));
		repeat ($urandom_range(10, 1)) poll(k, $urandom_range(step_max));
		if ($urandom_range(4) == 0) begin
			k = 16'h1 << $urandom_range(15);
			repeat ($urandom_range(8, 1)) poll(k, $urandom_range(step_max));
		end
		repeat ($urandom_range(3))
			poll($urandom_range(1) ? k : 16'($urandom), $urandom_range(bounce_max));
		repeat ($urandom_range(8, 1)) poll(16'h0, $urandom_range(step_max));
	endtask

	task automatic run_phase(input int ph, input logic [15:0] d, input logic [15:0] s,
		input logic [15:0] h, input int unsigned count);
		int unsigned step_max;
		int unsigned goal;
		int unsigned widest;
		quiesce();
		set_timing(d, s, h);
		case (ph % 4)
			0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
			1: begin tx_idle_pct = 54; rx_stall_pct = 0; end
			2: begin tx_idle_pct = 0; rx_stall_pct = 54; end
			default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
		endcase
		if (ph == 0 || ph == 4)
			hold_asks++;
		widest = d;
		if (s > widest) widest = s;
		if (h > widest) widest = h;
		step_max = widest / 3 + 2;
		case ($urandom_range(2))
			0: clock_ms = $urandom;
			1: clock_ms = 32'hFFFF_FFFF - $urandom_range(4 * step_max);
			default: ;
		endcase
		goal = polls_sent + count;
		while (polls_sent < goal) begin
			if ($urandom_range(9) == 0)
				poll(16'($urandom), ($urandom_range(19) == 0) ? $urandom : $urandom_range(step_max));
			else
				key_stroke(step_max);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: 15 / 1000 / 2000
		send_poll(16'h0000, 32'd0);
		send_poll(16'h8000, 32'd10);
		send_poll(16'h8000, 32'd25);
		send_poll(16'hFFFF, 32'd30);
		send_poll(16'hFFFF, 32'd45);
		send_poll(16'hFFFF, 32'd2045);
		send_poll(16'h0000, 32'd2050);
		send_poll(16'h0000, 32'd2065);
		send_poll(16'h0010, 32'hFFFF_FFF0);
		send_poll(16'h0010, 32'hFFFF_FFFF);
		send_poll(16'h0000, 32'd5);
		send_poll(16'h0000, 32'd20);
		// zero debounce, zero hold and zero short limit
		quiesce();
		set_timing(16'd0, 16'd0, 16'd0);
		send_poll(16'h0100, 32'd100);
		send_poll(16'h0000, 32'd100);
		send_poll(16'h0200, 32'd101);
		send_poll(16'h0000, 32'd102);

		run_phase(0, 16'd15, 16'd1000, 16'd2000, 115);
		run_phase(1, 16'd3, 16'd40, 16'd80, 115);
		run_phase(2, 16'd0, 16'd65535, 16'd1, 115);
		run_phase(3, 16'd65535, 16'd0, 16'd65535, 115);
		run_phase(4, 16'd10, 16'd100, 16'd0, 115);
		run_phase(5, 16'($urandom_range(50)), 16'($urandom_range(300)),
			16'($urandom_range(400)), 115);
		run_phase(6, 16'($urandom), 16'($urandom), 16'($urandom), 115);
		run_phase(7, 16'd1, 16'd20, 16'd20, 115);

		quiesce();
		repeat (10) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("keypad_debounce_press_classifier_unit test passed");
		else
			$display("keypad_debounce_press_classifier_unit test failed");
		$finish;
	end

endmodule
